// ===== rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes for the double-ended byte queue
// Command and response word layouts, operation and status codes.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
  } dq_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } dq_rsp_t;

endpackage

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue of bytes
// Throughput: one command word per cycle while responses are taken.
// Each taken word waits in the in-flight registers, where the synchronous read
//   port of the entry memory registers its data, then moves to the response register.
// Reset (synchronous): head, tail, fill count, busy and rsp_valid clear; entry storage is not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  dq_pkg::dq_cmd_t  cmd,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output dq_pkg::dq_rsp_t  rsp
);
  import dq_pkg::*;

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_CNT = FILL_W'(DEPTH);

  // Entry storage: written on a successful push, read data registered for every taken word.
  logic [DATA_W-1:0] entries [DEPTH];
  logic [DATA_W-1:0] rdata;

  // Ring pointers and exact fill level.
  logic [IDX_W-1:0]  head, head_next;
  logic [IDX_W-1:0]  tail, tail_next;
  logic [FILL_W-1:0] fill, fill_next;

  // Word in flight: waits for the registered memory read, then moves to rsp when free.
  logic              busy;
  logic              pend_use_rdata, use_rdata_next;
  logic [STAT_W-1:0] pend_status, status_next;
  logic [CNT_W-1:0]  pend_count;

  // Memory access for the incoming word.
  logic [IDX_W-1:0]  mem_addr;
  logic              mem_we;

  logic accept;
  logic load;
  logic is_full;
  logic is_empty;
  logic [IDX_W-1:0] head_prev, head_succ, tail_prev, tail_succ;

  // Output register is free when empty or being drained this cycle.
  assign load      = busy && (!rsp_valid || !rsp_stall);
  // Take a new word unless the one in flight cannot leave.
  assign cmd_stall = busy && !load;
  assign accept    = cmd_valid && !cmd_stall;

  assign is_full  = (fill == FULL_CNT);
  assign is_empty = (fill == '0);

  // Wrap pointers by compare, since DEPTH need not be a power of two.
  assign head_prev = (head == '0)       ? LAST_IDX : head - 1'b1;
  assign head_succ = (head == LAST_IDX) ? '0       : head + 1'b1;
  assign tail_prev = (tail == '0)       ? LAST_IDX : tail - 1'b1;
  assign tail_succ = (tail == LAST_IDX) ? '0       : tail + 1'b1;

  // Decode the command word: new pointers, status and memory access.
  always_comb begin
    head_next      = head;
    tail_next      = tail;
    fill_next      = fill;
    status_next    = ST_OK;
    use_rdata_next = 1'b0;
    mem_addr       = head;
    mem_we         = 1'b0;
    case (cmd.op)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          head_next = head_prev;
          mem_addr  = head_prev;
          mem_we    = 1'b1;
          fill_next = fill + 1'b1;
        end
      end
      OP_PUSH_REAR: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          tail_next = tail_succ;
          mem_addr  = tail;
          mem_we    = 1'b1;
          fill_next = fill + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          head_next      = head_succ;
          mem_addr       = head;
          use_rdata_next = 1'b1;
          fill_next      = fill - 1'b1;
        end
      end
      OP_POP_REAR: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          tail_next      = tail_prev;
          mem_addr       = tail_prev;
          use_rdata_next = 1'b1;
          fill_next      = fill - 1'b1;
        end
      end
      OP_PEEK_FRONT: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          mem_addr       = head;
          use_rdata_next = 1'b1;
        end
      end
      default: begin
        // Unused codes: no operation, report the current fill.
      end
    endcase
  end

  // Entry memory: write on a successful push; capture read data only when a
  // word is taken, so it holds while that word waits for the response slot.
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      entries[mem_addr] <= cmd.value;
    end
    if (accept) begin
      rdata <= entries[mem_addr];
    end
  end

  // Pointers, fill and flow control.
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        head <= head_next;
        tail <= tail_next;
        fill <= fill_next;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (load) begin
        busy <= 1'b0;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold the decoded result of the word in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_use_rdata <= use_rdata_next;
      pend_status    <= status_next;
      pend_count     <= CNT_W'(fill_next);
    end
  end

  // Response register: advance only when free, so a stalled word holds.
  always_ff @(posedge clk) begin
    if (load) begin
      rsp.result_value <= pend_use_rdata ? rdata : '0;
      rsp.status       <= pend_status;
      rsp.count        <= pend_count;
    end
  end

  // Fill level never passes capacity.
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_CNT)
    else $error("fill level above capacity");

  // A full report always carries the full count.
  a_full_count : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.count == CNT_W'(DEPTH))
    else $error("full status with wrong count");

  // An empty report carries zero count and zero value.
  a_empty_resp : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_EMPTY |-> rsp.count == '0 && rsp.result_value == '0)
    else $error("empty status with non-zero fields");

  // A response word only appears after a word was in flight.
  a_rsp_source : assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(busy))
    else $error("response without command in flight");

endmodule
